// ===== design/orfc_pkg.sv =====
// shared types and constants for the overwrite ring frame capture block
package orfc_pkg;

	localparam int STORE_DEPTH   = 2048;
	localparam int MAX_BURST     = 64;
	localparam int ADDR_W        = $clog2(STORE_DEPTH);
	localparam int FILL_W        = $clog2(STORE_DEPTH + 1);
	localparam int CNT_W         = $clog2(MAX_BURST + 1);
	localparam int IDLE_W        = 20;
	localparam int AVAIL_W       = 12;
	localparam int TIMEOUT_RESET = 10000;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] CMD_PUSH   = 2'd0;
	localparam logic [1:0] CMD_READ   = 2'd1;
	localparam logic [1:0] CMD_STATUS = 2'd2;
	localparam logic [1:0] CMD_TICK   = 2'd3;

	typedef enum logic [1:0] {
		OP_PUSH,
		OP_READ,
		OP_STATUS,
		OP_TICK
	} op_t;

	typedef enum logic {
		BK_IDLE,
		BK_BURST
	} back_state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] frame_word;
		logic [6:0]  read_count;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic               frame_valid;
		logic               last;
		logic [11:0]        frames_available;
		logic               clock_ok;
	} out_item_t;

	// classified command held in the queue between front and back
	typedef struct packed {
		op_t              op;
		logic [31:0]      frame;
		logic [CNT_W-1:0] want;
	} q_item_t;

endpackage

// ===== design/orfc_front.sv =====
// front end: command decode, burst length clamp and a short item queue
module orfc_front
	import orfc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  in_item_t request,
	input  logic     pop,
	output logic     busy,
	output logic     q_empty,
	output q_item_t  head
);

	q_item_t           entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	q_item_t           decoded;
	logic              accept;
	logic              do_pop;

	// classify the command; a zero-length read behaves as a status query
	always_comb begin
		decoded.frame = request.frame_word;
		if (request.read_count > 7'(MAX_BURST))
			decoded.want = CNT_W'(MAX_BURST);
		else
			decoded.want = CNT_W'(request.read_count);
		unique case (request.command)
			CMD_PUSH:   decoded.op = OP_PUSH;
			CMD_READ:   decoded.op = (request.read_count == 7'd0) ? OP_STATUS : OP_READ;
			CMD_STATUS: decoded.op = OP_STATUS;
			CMD_TICK:   decoded.op = OP_TICK;
			default:    decoded.op = OP_STATUS;
		endcase
	end

	assign busy    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign accept  = start && !busy;
	assign do_pop  = pop && !q_empty;
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (accept)
			entry_q[wr_ptr_q] <= decoded;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (accept && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!accept && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== design/orfc_back.sv =====
// back end: ring store, fill and idle tracking, burst sequencer, result stage
module orfc_back
	import orfc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  q_item_t           head,
	output logic              pop,
	input  logic              cfg_write,
	input  logic [IDLE_W-1:0] cfg_data,
	output logic              result_valid,
	output out_item_t         result
);

	localparam int CMP_W = (FILL_W > CNT_W) ? FILL_W : CNT_W;
	localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

	logic [31:0]       store [STORE_DEPTH];
	back_state_t       state_q, state_next;
	logic [ADDR_W-1:0] wr_idx_q, rd_idx_q;
	logic [FILL_W-1:0] fill_q;
	logic [IDLE_W-1:0] idle_q;
	logic [IDLE_W-1:0] timeout_q;
	logic              seen_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              res_valid_s1;
	logic              frame_s1;
	logic              last_s1;
	logic [AVAIL_W-1:0] avail_s1;
	logic              clk_ok_s1;
	logic [31:0]       rd_data_s1;

	logic [CNT_W-1:0]  burst_len;
	logic              do_push, do_tick, do_status, do_issue, issue_last;
	logic              clk_ok;
	logic              full;
	logic [FILL_W-1:0] fill_after;

	function automatic logic [ADDR_W-1:0] next_idx(input logic [ADDR_W-1:0] idx);
		return (idx == ADDR_W'(STORE_DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	function automatic logic [AVAIL_W-1:0] avail_of(input logic [FILL_W-1:0] f);
		logic [CMP_W+AVAIL_W-1:0] wide;
		wide = (CMP_W + AVAIL_W)'(f);
		return (wide > (CMP_W + AVAIL_W)'({AVAIL_W{1'b1}})) ? '1 : AVAIL_W'(f);
	endfunction

	assign clk_ok = seen_q && (idle_q < timeout_q);
	assign full   = (fill_q == FILL_W'(STORE_DEPTH));

	// frames this read returns: clamped request against what is held
	always_comb begin
		if (CMP_W'(head.want) < CMP_W'(fill_q))
			burst_len = head.want;
		else
			burst_len = CNT_W'(fill_q);
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty && head.op == OP_READ && burst_len > CNT_W'(1))
					state_next = BK_BURST;
			end
			BK_BURST: begin
				if (cnt_q == CNT_W'(1))
					state_next = BK_IDLE;
			end
			default: state_next = BK_IDLE;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		do_push    = 1'b0;
		do_tick    = 1'b0;
		do_status  = 1'b0;
		do_issue   = 1'b0;
		issue_last = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					unique case (head.op)
						OP_PUSH:   do_push = 1'b1;
						OP_TICK:   do_tick = 1'b1;
						OP_STATUS: do_status = 1'b1;
						OP_READ: begin
							if (burst_len == '0) begin
								do_status = 1'b1;
							end else begin
								do_issue   = 1'b1;
								issue_last = (burst_len == CNT_W'(1));
							end
						end
						default: do_status = 1'b1;
					endcase
				end
			end
			BK_BURST: begin
				do_issue   = 1'b1;
				issue_last = (cnt_q == CNT_W'(1));
			end
			default: ;
		endcase
	end

	assign fill_after = do_issue ? fill_q - 1'b1 : fill_q;

	// ring store, one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (do_push)
			store[wr_idx_q] <= head.frame;
		if (do_issue)
			rd_data_s1 <= store[rd_idx_q];
	end

	always_ff @(posedge clk) begin
		frame_s1  <= do_issue;
		last_s1   <= issue_last || do_status;
		avail_s1  <= avail_of(fill_after);
		clk_ok_s1 <= clk_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			wr_idx_q     <= '0;
			rd_idx_q     <= '0;
			fill_q       <= '0;
			idle_q       <= '0;
			seen_q       <= 1'b0;
			timeout_q    <= IDLE_W'(TIMEOUT_RESET);
			cnt_q        <= '0;
			res_valid_s1 <= 1'b0;
		end else begin
			state_q      <= state_next;
			res_valid_s1 <= do_issue || do_status;
			if (cfg_write)
				timeout_q <= cfg_data;
			if (do_push) begin
				wr_idx_q <= next_idx(wr_idx_q);
				if (full)
					rd_idx_q <= next_idx(rd_idx_q);
				else
					fill_q <= fill_q + 1'b1;
				idle_q <= '0;
				seen_q <= 1'b1;
			end
			if (do_tick && idle_q != IDLE_MAX)
				idle_q <= idle_q + 1'b1;
			if (do_issue) begin
				rd_idx_q <= next_idx(rd_idx_q);
				fill_q   <= fill_after;
				if (state_q == BK_IDLE)
					cnt_q <= burst_len - 1'b1;
				else
					cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign result_valid            = res_valid_s1;
	assign result.left_sample      = frame_s1 ? rd_data_s1[31:16] : 16'sd0;
	assign result.right_sample     = frame_s1 ? rd_data_s1[15:0] : 16'sd0;
	assign result.frame_valid      = frame_s1;
	assign result.last             = last_s1;
	assign result.frames_available = avail_s1;
	assign result.clock_ok         = clk_ok_s1;

endmodule

// ===== design/overwrite_ring_frame_capture.sv =====
// top level of the overwrite ring frame capture block
//
// command channel: an item (push, read burst, status query, tick) is taken
//   at a rising edge with start high and busy low; busy rises while the
//   two-entry item queue between front and back is full
// results: at most one per cycle, flagged by result_valid for exactly one
//   cycle; the receiver has no way to stall, so every strobe counts
// first result: an item's result passes through the queue and then the
//   store read register, and may wait while a read burst is in progress
// sequencing: push, tick and status are handled one at a time; a read burst
//   returns its frames back to back, one ring store read port access each
// the ring store holds 2048 frames; a push into a full store drops the oldest
// empty or zero-length reads give one frameless result with last set
// clock_ok is reported as seen at the time each result is formed
// configuration: cfg_data sets the idle timeout; cfg_ready is always high and
//   writes are expected only while the block is idle
// reset: pointers, fill, idle count and seen flag clear, timeout returns to
//   10000 ticks; store contents stay undefined and need no clearing pass
module overwrite_ring_frame_capture
	import orfc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  in_item_t          request,
	output logic              result_valid,
	output out_item_t         result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDLE_W-1:0] cfg_data
);

	logic    q_empty;
	logic    pop;
	q_item_t head;

	assign cfg_ready = 1'b1;

	// front: decode and queue
	orfc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.pop     (pop),
		.busy    (busy),
		.q_empty (q_empty),
		.head    (head)
	);

	// back: store, counters and burst sequencing
	orfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.head         (head),
		.pop          (pop),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	// a result without a frame always closes its item
	a_frameless_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.frame_valid |-> result.last)
		else $error("frameless result without last");

	// frameless results carry zero samples
	a_frameless_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.frame_valid |->
			result.left_sample == 16'sd0 && result.right_sample == 16'sd0)
		else $error("frameless result with nonzero samples");

	// a non-final frame is followed directly by the next frame of the burst
	a_burst_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.frame_valid && !result.last |=>
			result_valid && result.frame_valid)
		else $error("burst broken before last");

	// the held count never exceeds the store depth
	a_avail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> 32'(result.frames_available) <= 32'(STORE_DEPTH))
		else $error("frames_available above store depth");

endmodule
